// ===== rtl/core/tscp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscp_pkg
// Constants shared by the tanh soft clipper and PWM mapper.
// ----------------------------------------------------------------------------
package tscp_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned MAG_W     = 25;
  localparam int unsigned X2_W      = 35;
  localparam int unsigned KX_W      = 36;
  localparam int unsigned HALF_KX_W = 18;
  localparam int unsigned PROD_W    = MAG_W + HALF_KX_W;
  localparam int unsigned DEN_W     = 39;
  localparam int unsigned NUM_W     = 61;
  localparam int unsigned Q_SHIFT   = 15;
  localparam int unsigned DIV_BITS  = 15;
  localparam int unsigned PWM_W     = 16;
  localparam int unsigned N_STAGES  = 3 + DIV_BITS + 1 + 2;

  localparam logic [KX_W-1:0]  PADE_K    = KX_W'(884736);
  localparam logic [14:0]      CLIP_MAX  = 15'd32767;
  localparam logic [PWM_W-1:0] RANGE_RST = 16'd1024;

endpackage

// ===== rtl/core/tanh_soft_clip_to_pwm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_soft_clip_to_pwm
// Pade tanh soft clipper on signed samples, mapped to a PWM count.
// ----------------------------------------------------------------------------
// Samples enter on the in_ stream channel, one item per accepted beat, and
// each gives one PWM level on the out_ stream channel, in order.
// The datapath is a fully pipelined chain of 21 register stages: tripling,
// squaring, split numerator multiply, a saturation check, fifteen restoring
// division stages (one quotient bit each) and two stages for the PWM scale.
// out_tvalid rises once an item has passed through every register stage,
// and one item can be accepted in every cycle unless the receiver stalls.
// When the receiver stalls a full pipeline holds in place; in_tready is low
// only while the last stage holds an item that is not taken.
// cfg_wr_en writes pwm_range; it should only change while no item is in
// flight. Reset empties the pipeline and sets pwm_range to 1024.
// ----------------------------------------------------------------------------
module tanh_soft_clip_to_pwm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pwm_level
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tscp_pkg::*;

  localparam int unsigned LAST = N_STAGES - 1;

  logic                en;
  logic [N_STAGES-1:0] vld_r;
  logic [PWM_W-1:0]    range_r;

  logic signed [MAG_W:0] x3;
  logic [MAG_W-1:0]      s0_mag_r, s1_mag_r;
  logic                  s0_sgn_r, s1_sgn_r, s2_sgn_r;
  logic [X2_W-1:0]       s1_x2_r;
  logic [2*MAG_W-1:0]    sq;
  logic [KX_W-1:0]       kx;
  logic [PROD_W-1:0]     s2_pl_r, s2_ph_r;
  logic [DEN_W-1:0]      s2_den_r;
  logic [NUM_W-1:0]      num;

  logic [NUM_W-1:0]    rem_r [0:DIV_BITS];
  logic [DEN_W-1:0]    den_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] quo_r [0:DIV_BITS];
  logic                sgn_r [0:DIV_BITS];
  logic                sat_r [0:DIV_BITS];

  logic [14:0]      cmag;
  logic [14:0]      half;
  logic [29:0]      m1_p_r;
  logic             m1_sgn_r;
  logic [14:0]      m1_half_r;
  logic [14:0]      q0;
  logic [16:0]      rfix;
  logic [15:0]      qq;
  logic [PWM_W-1:0] lvl_r;

  function automatic logic [2*MAG_W-1:0] s1_mag_w(input logic [MAG_W-1:0] m);
    s1_mag_w = m * m;
  endfunction

  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      range_r <= RANGE_RST;
    end else begin
      if (en) begin
        vld_r <= {vld_r[N_STAGES-2:0], in_tvalid};
      end
      if (cfg_wr_en) begin
        range_r <= cfg_wr_data;
      end
    end
  end

  assign x3   = (MAG_W+1)'($signed(in_tdata)) * 26'sd3;
  assign sq   = s1_mag_w(s0_mag_r);
  assign kx   = PADE_K + KX_W'(s1_x2_r);
  assign num  = NUM_W'(s2_pl_r) + (NUM_W'(s2_ph_r) << HALF_KX_W);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag_r <= x3[MAG_W] ? MAG_W'(-x3) : x3[MAG_W-1:0];
      s0_sgn_r <= x3[MAG_W];
      s1_x2_r  <= sq[2*MAG_W-1:Q_SHIFT];
      s1_mag_r <= s0_mag_r;
      s1_sgn_r <= s0_sgn_r;
      s2_pl_r  <= s1_mag_r * kx[HALF_KX_W-1:0];
      s2_ph_r  <= s1_mag_r * kx[KX_W-1:HALF_KX_W];
      s2_den_r <= DEN_W'(PADE_K) + (DEN_W'(s1_x2_r) << 3) + DEN_W'(s1_x2_r);
      s2_sgn_r <= s1_sgn_r;
      rem_r[0] <= num;
      den_r[0] <= s2_den_r;
      quo_r[0] <= '0;
      sgn_r[0] <= s2_sgn_r;
      sat_r[0] <= num >= (NUM_W'(s2_den_r) << DIV_BITS);
    end
  end

  for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
    localparam int unsigned BIT = DIV_BITS - j;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    assign dsh = NUM_W'(den_r[j-1]) << BIT;
    assign ge  = rem_r[j-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - dsh : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        quo_r[j] <= quo_r[j-1] | (DIV_BITS'(ge) << BIT);
        sgn_r[j] <= sgn_r[j-1];
        sat_r[j] <= sat_r[j-1];
      end
    end
  end

  assign cmag = sat_r[DIV_BITS] ? CLIP_MAX : quo_r[DIV_BITS];
  assign half = range_r[PWM_W-1:1];
  assign q0   = m1_p_r[29:15];
  assign rfix = 17'(m1_p_r[14:0]) + 17'(q0);

  always_comb begin
    priority if (rfix >= 17'(2 * 32767)) begin
      qq = 16'(q0) + 16'd2;
    end else if (rfix >= 17'(CLIP_MAX)) begin
      qq = 16'(q0) + 16'd1;
    end else begin
      qq = 16'(q0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p_r    <= cmag * half;
      m1_sgn_r  <= sgn_r[DIV_BITS];
      m1_half_r <= half;
      lvl_r     <= m1_sgn_r ? 16'(m1_half_r) - qq : 16'(m1_half_r) + qq;
    end
  end

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= range_r)
    else $error("pwm level above range");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3 + DIV_BITS] && !sat_r[DIV_BITS] |-> rem_r[DIV_BITS] < NUM_W'(den_r[DIV_BITS]))
    else $error("division remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("pipeline moved during stall");

endmodule
